// ----- hdl/splb_pkg.sv -----
package splb_pkg;

  // Default number of 64-bit words in the label.
  localparam int DEF_LABEL_WORDS = 4;

  localparam int WIN_BITS = 64;
  localparam int SHIFT_W  = 6;

  // One continuation bit at the top of every nibble of a window.
  localparam logic [WIN_BITS-1:0] PBIT_PATTERN = 64'h8888_8888_8888_8888;
  localparam logic [WIN_BITS-1:0] WIN_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_SPAWN_LEFT  = 2'd0,
    FUNC_SPAWN_RIGHT = 2'd1,
    FUNC_SYNC        = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0] func;
    logic [8:0] restore_point;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [8:0] end_point;
  } rsp_t;

  // Position of the highest set bit; zero when no bit is set.
  function automatic logic [SHIFT_W-1:0] top_bit(input logic [WIN_BITS-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_BITS; i++) begin
      if (v[i]) begin
        n = SHIFT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/splb_in_reg.sv -----
module splb_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        func,
  input  logic [8:0]        restore_point,
  input  logic              drain,
  output logic              hold_valid,
  output splb_pkg::item_t   item
);

  logic take;

  // The held request leaves when it is committed, so a new one may enter then.
  assign req_ready = !hold_valid || drain;
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.func          <= func;
      item.restore_point <= restore_point;
    end
  end

endmodule

// ----- hdl/splb_update.sv -----
module splb_update #(
  parameter int LABEL_WORDS = splb_pkg::DEF_LABEL_WORDS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            commit,
  input  splb_pkg::item_t item,
  output splb_pkg::rsp_t  result
);

  localparam int LBL_BYTES = LABEL_WORDS * 8;
  localparam int LBL_BITS  = LABEL_WORDS * 64;
  localparam int EW_MIN    = $clog2(LBL_BITS + 1);
  localparam int EW        = (EW_MIN > 9) ? EW_MIN : 9;
  localparam int SW        = $clog2(LBL_BITS);
  localparam int WB        = splb_pkg::WIN_BITS;
  localparam int XW        = splb_pkg::SHIFT_W;

  localparam logic [EW-1:0] MAX_BASE = EW'(LBL_BYTES - 8);
  localparam logic [EW-1:0] CAP_BITS = EW'(LBL_BITS);
  localparam logic [EW-1:0] CAP_BYTE = EW'(LBL_BYTES);

  logic [LBL_BITS-1:0] label, label_next;
  logic [EW-1:0]       end_pos, end_next;
  logic                ok;

  // Spawn path.
  logic [EW-1:0] s_base, s_low, s_new;
  logic [WB-1:0] s_win, s_vec;
  logic [XW-1:0] s_hi;
  logic          s_ok;

  // Sync path.
  logic [EW-1:0]       y_r, y_base, y_low, clr_lo, clr_hi, end_bytes;
  logic [WB-1:0]       y_win, pm, conts, y_a, carries, y_b, y_vec;
  logic [SW-1:0]       y_sh;
  logic                y_ok;
  logic [LBL_BITS-1:0] y_label;

  always_comb begin
    s_base = ((end_pos >> 3) > MAX_BASE) ? MAX_BASE : (end_pos >> 3);
    s_low  = end_pos - (s_base << 3);
    s_win  = WB'(label >> SW'(s_base << 3));
    s_vec  = s_win | (WB'(1) << s_low[XW-1:0]);
    s_hi   = splb_pkg::top_bit(s_vec);
    s_new  = ((EW'(s_hi) + EW'(2)) | EW'(3)) + EW'(1) + (s_base << 3);
    s_ok   = (end_pos <= CAP_BITS) && (s_low < EW'(WB)) && (s_new <= CAP_BITS);
  end

  always_comb begin
    y_r     = EW'(item.restore_point);
    y_base  = ((y_r >> 3) > MAX_BASE) ? MAX_BASE : (y_r >> 3);
    y_low   = y_r - (y_base << 3);
    y_sh    = SW'(y_base << 3);
    y_ok    = (y_r <= CAP_BITS) && (y_r[1:0] == 2'b00) && (y_low < EW'(WB));
    y_win   = WB'(label >> y_sh);
    // Clear every continuation bit and everything above the lowest one,
    // then bump the nibble counter and put back the carry markers.
    pm      = splb_pkg::PBIT_PATTERN << y_low[XW-1:0];
    conts   = y_win & pm;
    y_a     = y_win & ~conts & (conts - WB'(1));
    carries = y_a & (pm >> 1);
    y_b     = (y_a | pm) + (WB'(1) << y_low[XW-1:0]);
    y_vec   = (y_b & ~pm) | carries;
    y_label = (label & ~(LBL_BITS'(splb_pkg::WIN_ONES) << y_sh))
            | (LBL_BITS'(y_vec) << y_sh);
    // Bytes above the window up to the old end are wiped.
    clr_lo    = y_base + EW'(8);
    end_bytes = (end_pos >> 3) + EW'(8);
    clr_hi    = (end_bytes > CAP_BYTE) ? CAP_BYTE : end_bytes;
    for (int a = 0; a < LBL_BYTES; a++) begin
      if ((EW'(a) >= clr_lo) && (EW'(a) < clr_hi)) begin
        y_label[a*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    ok         = 1'b0;
    label_next = label;
    end_next   = end_pos;
    unique case (splb_pkg::func_t'(item.func))
      splb_pkg::FUNC_SPAWN_LEFT: begin
        ok = s_ok;
        if (s_ok) begin
          end_next = s_new;
        end
      end
      splb_pkg::FUNC_SPAWN_RIGHT: begin
        ok = s_ok;
        if (s_ok) begin
          end_next   = s_new;
          label_next = label | (LBL_BITS'(1) << SW'(s_new - EW'(1)));
        end
      end
      splb_pkg::FUNC_SYNC: begin
        ok = y_ok;
        if (y_ok) begin
          end_next   = y_r;
          label_next = y_label;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    result.status    = !ok;
    result.end_point = end_next[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label   <= '0;
      end_pos <= '0;
    end else if (commit && ok) begin
      label   <= label_next;
      end_pos <= end_next;
    end
  end

endmodule

// ----- hdl/splb_out_reg.sv -----
module splb_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  splb_pkg::rsp_t result,
  output logic           can_load,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output logic           status,
  output logic [8:0]     end_point
);

  splb_pkg::rsp_t held;

  // The register may be refilled in the same cycle as it is emptied.
  assign can_load  = !rsp_valid || rsp_ready;
  assign status    = held.status;
  assign end_point = held.end_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

endmodule

// ----- hdl/series_parallel_label_update.sv -----
// Series-parallel label update.
// The block keeps a bit label of LABEL_WORDS 64-bit words and an end position.
// Each request on the req channel (req_valid/req_ready, func, restore_point)
// carries one event: spawn a left child, spawn a right child, or sync back to
// a restore point. Every request gives exactly one response on the rsp
// channel (rsp_valid/rsp_ready, status, end_point): status is high when the
// event would overflow the label or names a bad restore point or function,
// in which case the state is left as it was; end_point is the end after it.
// An accepted request sits in the input register until the response register
// has room; then the label update and response register take it in one pass.
// Throughput is one request per cycle while rsp_ready holds; the update of one
// request is seen by the next; state is written as its response is captured.
// While the receiver stalls, the pending response is held and one further
// request may wait in the input register; req_ready then drops.
// Reset clears the label and the end position and empties both registers.
module series_parallel_label_update #(
  parameter int LABEL_WORDS = splb_pkg::DEF_LABEL_WORDS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] func,
  input  logic [8:0] restore_point,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic       status,
  output logic [8:0] end_point
);

  logic            hold_valid;
  logic            can_load;
  logic            commit;
  splb_pkg::item_t item;
  splb_pkg::rsp_t  result;

  // A held request is processed as soon as the response register has room.
  assign commit = hold_valid && can_load;

  splb_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .func          (func),
    .restore_point (restore_point),
    .drain         (commit),
    .hold_valid    (hold_valid),
    .item          (item)
  );

  splb_update #(
    .LABEL_WORDS (LABEL_WORDS)
  ) u_update (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (item),
    .result (result)
  );

  splb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (hold_valid),
    .result    (result),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .end_point (end_point)
  );

`ifndef SYNTHESIS
  // The end always sits on a nibble boundary.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (end_point[1:0] == 2'b00))
    else $error("end_point is not nibble aligned");

  // A ready receiver never stalls the request side.
  assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("request stalled while the response side is ready");

  // A held request reaches the response register on the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !rsp_valid) |=> rsp_valid)
    else $error("held request did not produce a response");
`endif

endmodule
